[src/lcdseq_pkg.sv]
package lcdseq_pkg;

   // request codes
   typedef enum logic [2:0] {
      FUNC_WRITE  = 3'd0,
      FUNC_CURSOR = 3'd1,
      FUNC_CLEAR  = 3'd2,
      FUNC_HOME   = 3'd3,
      FUNC_INIT   = 3'd4
   } func_type;

   // register indexes on the configuration port
   typedef enum logic [1:0] {
      REG_PULSE      = 2'd0,
      REG_BYTE_WAIT  = 2'd1,
      REG_CLEAR_WAIT = 2'd2
   } reg_index_type;

   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   localparam logic [7:0]  PULSE_RESET      = 8'd5;
   localparam logic [15:0] BYTE_WAIT_RESET  = 16'd2000;
   localparam logic [15:0] CLEAR_WAIT_RESET = 16'd2000;

   // display commands
   localparam logic [7:0] CMD_SET_ADDR   = 8'h80;
   localparam logic [7:0] CMD_FUNC_SET   = 8'h28;
   localparam logic [7:0] CMD_DISPLAY_ON = 8'h0C;
   localparam logic [7:0] CMD_ENTRY_MODE = 8'h06;
   localparam logic [7:0] CMD_CLEAR      = 8'h01;
   localparam logic [7:0] CMD_HOME       = 8'h02;

   // power-up sequence
   localparam logic [3:0]  WAKE_NIBBLE  = 4'h3;
   localparam logic [3:0]  WAKE_FINAL   = 4'h2;
   localparam logic [15:0] OPEN_WAIT_US = 16'd15000;
   localparam int INIT_EVENTS    = 25;
   localparam int WAKE_FIRST     = 1;
   localparam int WAKE_EVENTS    = 8;
   localparam int INIT_BYTE_BASE = WAKE_FIRST + WAKE_EVENTS;
   localparam int STEP_W         = $clog2(INIT_EVENTS);

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   // one classified request
   typedef struct packed {
      logic       is_init;
      logic       rs;
      logic [7:0] byte_value;
      logic       add_clear;
   } job_type;

   function automatic logic [7:0] row_offset(input logic [1:0] row);
      logic [7:0] offset;
      case (row)
         2'd0:    offset = 8'h00;
         2'd1:    offset = 8'h40;
         2'd2:    offset = 8'h14;
         default: offset = 8'h54;
      endcase
      return offset;
   endfunction

   // extra hold after each wake-up nibble
   function automatic logic [15:0] wake_extra(input logic [1:0] idx);
      logic [15:0] extra;
      case (idx)
         2'd0:    extra = 16'd5000;
         2'd1:    extra = 16'd160;
         2'd2:    extra = 16'd160;
         default: extra = 16'd10000;
      endcase
      return extra;
   endfunction

   // command bytes that close the power-up sequence
   function automatic logic [7:0] init_byte(input logic [1:0] idx);
      logic [7:0] cmd;
      case (idx)
         2'd0:    cmd = CMD_FUNC_SET;
         2'd1:    cmd = CMD_DISPLAY_ON;
         2'd2:    cmd = CMD_ENTRY_MODE;
         default: cmd = CMD_CLEAR;
      endcase
      return cmd;
   endfunction

   function automatic logic [15:0] sat_add(input logic [15:0] a, input logic [15:0] b);
      logic [16:0] sum;
      sum = {1'b0, a} + {1'b0, b};
      return sum[16] ? 16'hFFFF : sum[15:0];
   endfunction

endpackage

[src/lcdseq_chan_if.sv]
interface lcdseq_req_if;
   logic       valid;
   logic       ready;
   logic [2:0] func;
   logic [7:0] byte_value;
   logic       register_select;
   logic [1:0] row;
   logic [5:0] column;

   modport source (output valid, func, byte_value, register_select, row, column,
                   input ready);
   modport sink   (input valid, func, byte_value, register_select, row, column,
                   output ready);
endinterface

interface lcdseq_rsp_if;
   logic        valid;
   logic        ready;
   logic        rs_pin;
   logic        enable_pin;
   logic [3:0]  data_nibble;
   logic [15:0] hold_us;
   logic        last;

   modport source (output valid, rs_pin, enable_pin, data_nibble, hold_us, last,
                   input ready);
   modport sink   (input valid, rs_pin, enable_pin, data_nibble, hold_us, last,
                   output ready);
endinterface

[src/lcdseq_front.sv]
module lcdseq_front (
   lcdseq_req_if.sink      req,
   input  logic            queue_full,
   output logic            push,
   output lcdseq_pkg::job_type job
);
   import lcdseq_pkg::*;

   logic       known;
   logic [7:0] cursor_addr;

   assign req.ready = !queue_full;

   // form the cursor address, wrapping to 8 bits
   assign cursor_addr = row_offset(req.row) + {2'b00, req.column};

   // classify the request; unknown codes are accepted and dropped
   always_comb begin
      known         = 1'b1;
      job.is_init   = 1'b0;
      job.rs        = 1'b0;
      job.byte_value = req.byte_value;
      job.add_clear = 1'b0;
      unique case (func_type'(req.func))
         FUNC_WRITE: begin
            job.rs = req.register_select;
         end
         FUNC_CURSOR: begin
            job.byte_value = CMD_SET_ADDR | cursor_addr;
         end
         FUNC_CLEAR: begin
            job.byte_value = CMD_CLEAR;
            job.add_clear  = 1'b1;
         end
         FUNC_HOME: begin
            job.byte_value = CMD_HOME;
            job.add_clear  = 1'b1;
         end
         FUNC_INIT: begin
            job.is_init = 1'b1;
         end
         default: begin
            known = 1'b0;
         end
      endcase
   end

   assign push = req.valid && req.ready && known;

endmodule

[src/lcdseq_queue.sv]
module lcdseq_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  lcdseq_pkg::job_type push_job,
   input  logic                pop,
   output lcdseq_pkg::job_type head,
   output logic                empty,
   output logic                full
);
   import lcdseq_pkg::*;

   job_type             entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]     count_ff, count_in;

   assign empty = (count_ff == '0);
   assign full  = (count_ff == (QPTR_W + 1)'(QUEUE_DEPTH));
   assign head  = entry_ff[rd_ptr_ff];

   // advance pointers and occupancy
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // store the pushed job
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

[src/lcdseq_back.sv]
module lcdseq_back (
   input  logic                clock,
   input  logic                reset,
   input  lcdseq_pkg::job_type head,
   input  logic                head_valid,
   input  logic [7:0]          pulse_us,
   input  logic [15:0]         byte_wait_us,
   input  logic [15:0]         clear_wait_us,
   output logic                pop,
   lcdseq_rsp_if.source        rsp
);
   import lcdseq_pkg::*;

   logic [STEP_W-1:0] step_ff, step_in;
   logic [STEP_W-1:0] wake_pos;
   logic [STEP_W-1:0] byte_pos;

   logic        fire;
   logic        ev_rs;
   logic        ev_en;
   logic [3:0]  ev_nib;
   logic [15:0] ev_hold;
   logic        ev_last;

   logic        bp_phase;
   logic [7:0]  bp_byte;
   logic [1:0]  bp_k;
   logic        bp_clear;
   logic [15:0] pulse16;
   logic [15:0] byte_extra;
   logic [15:0] byte_end_hold;

   logic        rsp_valid_ff, rsp_valid_in;
   logic        rs_pin_ff;
   logic        enable_pin_ff;
   logic [3:0]  data_nibble_ff;
   logic [15:0] hold_us_ff;
   logic        last_ff;

   assign pulse16  = {8'h00, pulse_us};
   assign wake_pos = step_ff - STEP_W'(WAKE_FIRST);
   assign byte_pos = step_ff - STEP_W'(INIT_BYTE_BASE);

   // pick the byte and nibble position for the current step
   always_comb begin
      bp_phase = 1'b1;
      bp_byte  = head.byte_value;
      bp_k     = step_ff[1:0];
      bp_clear = head.add_clear;
      if (head.is_init) begin
         if (step_ff < STEP_W'(INIT_BYTE_BASE)) begin
            bp_phase = 1'b0;
         end
         bp_byte  = init_byte(byte_pos[3:2]);
         bp_k     = byte_pos[1:0];
         bp_clear = (byte_pos[3:2] == 2'd3);
      end
   end

   assign byte_extra    = sat_add(byte_wait_us, bp_clear ? clear_wait_us : 16'h0000);
   assign byte_end_hold = sat_add(pulse16, byte_extra);

   // decode the pin event for the current step
   always_comb begin
      ev_rs   = head.is_init ? 1'b0 : head.rs;
      ev_en   = 1'b0;
      ev_nib  = 4'h0;
      ev_hold = OPEN_WAIT_US;
      if (bp_phase) begin
         ev_en   = ~bp_k[0];
         ev_nib  = bp_k[1] ? bp_byte[3:0] : bp_byte[7:4];
         ev_hold = (bp_k == 2'd3) ? byte_end_hold : pulse16;
      end else if (step_ff != '0) begin
         ev_en   = ~wake_pos[0];
         ev_nib  = (wake_pos[2:1] == 2'd3) ? WAKE_FINAL : WAKE_NIBBLE;
         ev_hold = wake_pos[0] ? sat_add(pulse16, wake_extra(wake_pos[2:1])) : pulse16;
      end
      ev_last = head.is_init ? (step_ff == STEP_W'(INIT_EVENTS - 1))
                             : (step_ff[1:0] == 2'd3);
   end

   // emit one event per cycle when the output register has room
   assign fire = head_valid && (!rsp_valid_ff || rsp.ready);
   assign pop  = fire && ev_last;

   always_comb begin
      step_in = step_ff;
      if (fire) begin
         step_in = ev_last ? '0 : step_ff + 1'b1;
      end
      rsp_valid_in = fire || (rsp_valid_ff && !rsp.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // hold the event until it is taken
   always_ff @(posedge clock) begin
      if (fire) begin
         rs_pin_ff      <= ev_rs;
         enable_pin_ff  <= ev_en;
         data_nibble_ff <= ev_nib;
         hold_us_ff     <= ev_hold;
         last_ff        <= ev_last;
      end
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.rs_pin      = rs_pin_ff;
   assign rsp.enable_pin  = enable_pin_ff;
   assign rsp.data_nibble = data_nibble_ff;
   assign rsp.hold_us     = hold_us_ff;
   assign rsp.last        = last_ff;

endmodule

[src/char_lcd_nibble_sequencer_top.sv]
// Character LCD nibble sequencer for a 4-bit bus. Each request (write byte,
// set cursor, clear, home, power-up init) is turned into pin events, one per
// clock when the consumer keeps rsp ready high: a write, cursor, clear or home
// request yields one byte as two nibbles, and init the full power-up sequence.
// The event sequencer sets that rate. Requests are taken every cycle while the
// four-entry job queue has room; unknown request codes are taken and dropped.
// Hold times, byte waits and the clear wait come from the three APB registers
// and saturate at 65535 us. Write the registers only while no transaction is
// in flight.
module char_lcd_nibble_sequencer_top (
   input  logic                              clock,
   input  logic                              reset,
   lcdseq_req_if.sink                        req_chan,
   lcdseq_rsp_if.source                      rsp_chan,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [lcdseq_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [lcdseq_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [lcdseq_pkg::CSR_DATA_W-1:0] prdata,
   output logic                              pready
);
   import lcdseq_pkg::*;

   logic [7:0]    pulse_us_ff;
   logic [15:0]   byte_wait_us_ff;
   logic [15:0]   clear_wait_us_ff;
   logic          csr_write;
   reg_index_type csr_index;

   job_type       push_job;
   job_type       head;
   logic          push;
   logic          pop;
   logic          q_empty;
   logic          q_full;

   // configuration registers
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;
   assign csr_index = reg_index_type'(paddr[3:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         pulse_us_ff      <= PULSE_RESET;
         byte_wait_us_ff  <= BYTE_WAIT_RESET;
         clear_wait_us_ff <= CLEAR_WAIT_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            REG_PULSE:      pulse_us_ff      <= pwdata[7:0];
            REG_BYTE_WAIT:  byte_wait_us_ff  <= pwdata[15:0];
            REG_CLEAR_WAIT: clear_wait_us_ff <= pwdata[15:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         REG_PULSE:      prdata = {24'h000000, pulse_us_ff};
         REG_BYTE_WAIT:  prdata = {16'h0000, byte_wait_us_ff};
         REG_CLEAR_WAIT: prdata = {16'h0000, clear_wait_us_ff};
         default:        prdata = '0;
      endcase
   end

   lcdseq_front u_front (
      .req        (req_chan),
      .queue_full (q_full),
      .push       (push),
      .job        (push_job)
   );

   lcdseq_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .head     (head),
      .empty    (q_empty),
      .full     (q_full)
   );

   lcdseq_back u_back (
      .clock         (clock),
      .reset         (reset),
      .head          (head),
      .head_valid    (!q_empty),
      .pulse_us      (pulse_us_ff),
      .byte_wait_us  (byte_wait_us_ff),
      .clear_wait_us (clear_wait_us_ff),
      .pop           (pop),
      .rsp           (rsp_chan)
   );

   // never push into a full queue
   assert property (@(posedge clock) disable iff (reset) push |-> !q_full)
      else $error("job pushed into full queue");

   // retire a job only when one is waiting
   assert property (@(posedge clock) disable iff (reset) pop |-> !q_empty)
      else $error("job popped from empty queue");

   // the output register comes out of reset empty
   assert property (@(posedge clock) reset |=> !rsp_chan.valid)
      else $error("event valid after reset");

endmodule

[verif/tb_char_lcd_nibble_sequencer_top.sv]
`timescale 1ns / 1ps

module tb_char_lcd_nibble_sequencer_top;
   import lcdseq_pkg::*;

   localparam int CYCLE_LIMIT   = 400000;
   localparam int SETTLE_CYCLES = 20;
   localparam int MAX_REPORTS   = 10;

   // one pin event on the display bus
   typedef struct packed {
      logic        rs;
      logic        en;
      logic [3:0]  nibble;
      logic [15:0] hold;
      logic        last;
   } pin_event_type;

   // one request as driven on the input channel
   typedef struct packed {
      logic [2:0] func;
      logic [7:0] byte_value;
      logic       register_select;
      logic [1:0] row;
      logic [5:0] column;
   } lcd_request_type;

   // Expands requests into pin events and checks the bus traffic against them
   class lcd_event_scoreboard_type;
      logic [7:0]    pulse_us;
      logic [15:0]   byte_wait_us;
      logic [15:0]   clear_wait_us;
      pin_event_type pending[$];
      int            requests;
      int            events_seen;
      int            mismatches;

      function new();
         pulse_us      = PULSE_RESET;
         byte_wait_us  = BYTE_WAIT_RESET;
         clear_wait_us = CLEAR_WAIT_RESET;
         requests      = 0;
         events_seen   = 0;
         mismatches    = 0;
      endfunction

      function void set_register(input reg_index_type idx, input logic [31:0] value);
         case (idx)
            REG_PULSE:      pulse_us      = value[7:0];
            REG_BYTE_WAIT:  byte_wait_us  = value[15:0];
            REG_CLEAR_WAIT: clear_wait_us = value[15:0];
            default: ;
         endcase
      endfunction

      // clamp a hold time at the 16-bit ceiling
      function logic [15:0] hold_sum(input int unsigned a, input int unsigned b);
         int unsigned total;
         total = a + b;
         return (total > 32'd65535) ? 16'hFFFF : total[15:0];
      endfunction

      function void push_event(input logic rs, input logic en, input logic [3:0] nib,
                               input logic [15:0] hold);
         pin_event_type ev;
         ev.rs     = rs;
         ev.en     = en;
         ev.nibble = nib;
         ev.hold   = hold;
         ev.last   = 1'b0;
         pending.push_back(ev);
      endfunction

      function void push_nibble(input logic rs, input logic [3:0] nib,
                                input logic [15:0] extra);
         push_event(rs, 1'b1, nib, {8'd0, pulse_us});
         push_event(rs, 1'b0, nib, hold_sum(pulse_us, extra));
      endfunction

      // high nibble first; the byte wait lands on the final enable-low event
      function void push_byte(input logic rs, input logic [7:0] val,
                              input logic [15:0] extra);
         push_nibble(rs, val[7:4], 16'd0);
         push_nibble(rs, val[3:0], hold_sum(byte_wait_us, extra));
      endfunction

      function logic [7:0] row_base(input logic [1:0] row);
         case (row)
            2'd0:    return 8'h00;
            2'd1:    return 8'h40;
            2'd2:    return 8'h14;
            default: return 8'h54;
         endcase
      endfunction

      // Predict the events of one accepted transaction
      function void note_request(input lcd_request_type r);
         int            base_count;
         logic [7:0]    addr;
         pin_event_type tail;
         base_count = pending.size();
         case (r.func)
            FUNC_WRITE: push_byte(r.register_select, r.byte_value, 16'd0);
            FUNC_CURSOR: begin
               addr = row_base(r.row) + {2'b00, r.column};
               push_byte(1'b0, CMD_SET_ADDR | addr, 16'd0);
            end
            FUNC_CLEAR: push_byte(1'b0, CMD_CLEAR, clear_wait_us);
            FUNC_HOME:  push_byte(1'b0, CMD_HOME, clear_wait_us);
            FUNC_INIT: begin
               push_event(1'b0, 1'b0, 4'h0, OPEN_WAIT_US);
               push_nibble(1'b0, WAKE_NIBBLE, 16'd5000);
               push_nibble(1'b0, WAKE_NIBBLE, 16'd160);
               push_nibble(1'b0, WAKE_NIBBLE, 16'd160);
               push_nibble(1'b0, WAKE_FINAL, 16'd10000);
               push_byte(1'b0, CMD_FUNC_SET, 16'd0);
               push_byte(1'b0, CMD_DISPLAY_ON, 16'd0);
               push_byte(1'b0, CMD_ENTRY_MODE, 16'd0);
               push_byte(1'b0, CMD_CLEAR, clear_wait_us);
            end
            default: ;
         endcase
         // mark the final event of this request
         if (pending.size() > base_count) begin
            tail = pending.pop_back();
            tail.last = 1'b1;
            pending.push_back(tail);
            requests++;
         end
      endfunction

      // Compare one accepted event with the oldest prediction
      function void check_event(input pin_event_type got);
         pin_event_type want;
         events_seen++;
         if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("%0t: unexpected event rs=%0b en=%0b d=%h hold=%0d last=%0b",
                        $time, got.rs, got.en, got.nibble, got.hold, got.last);
            return;
         end
         want = pending.pop_front();
         if (got.rs !== want.rs || got.en !== want.en || got.nibble !== want.nibble ||
             got.hold !== want.hold || got.last !== want.last) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS) begin
               $write("%0t: event mismatch, expected rs=%0b en=%0b d=%h hold=%0d last=%0b",
                      $time, want.rs, want.en, want.nibble, want.hold, want.last);
               $display(" got rs=%0b en=%0b d=%h hold=%0d last=%0b",
                        got.rs, got.en, got.nibble, got.hold, got.last);
            end
         end
      endfunction
   endclass

   logic                  clock;
   logic                  reset;
   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [CSR_DATA_W-1:0] pwdata;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   lcdseq_req_if req_if();
   lcdseq_rsp_if rsp_if();

   lcd_event_scoreboard_type sb;
   logic steady;
   int   cycle_count;
   int   settings_used;

   char_lcd_nibble_sequencer_top dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // abort a hung run
   initial cycle_count = 0;
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // note every accepted request transaction
   always @(posedge clock) begin
      if (reset == 1'b0 && req_if.valid && req_if.ready)
         sb.note_request({req_if.func, req_if.byte_value, req_if.register_select,
                          req_if.row, req_if.column});
   end

   // check every accepted event transaction
   always @(posedge clock) begin
      if (reset == 1'b0 && rsp_if.valid && rsp_if.ready)
         sb.check_event({rsp_if.rs_pin, rsp_if.enable_pin, rsp_if.data_nibble,
                         rsp_if.hold_us, rsp_if.last});
   end

   // Stall the event channel a random number of cycles per transaction
   initial begin
      int stall;
      rsp_if.ready <= 1'b0;
      do @(posedge clock); while (reset !== 1'b0);
      forever begin
         stall = steady ? 0 : $urandom_range(0, 7);
         if (stall > 0) begin
            rsp_if.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_if.ready <= 1'b1;
         do @(posedge clock); while (!rsp_if.valid);
      end
   end

   task automatic send_request(input lcd_request_type r);
      int gap;
      gap = steady ? 0 : $urandom_range(0, 7);
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid           <= 1'b1;
      req_if.func            <= r.func;
      req_if.byte_value      <= r.byte_value;
      req_if.register_select <= r.register_select;
      req_if.row             <= r.row;
      req_if.column          <= r.column;
      do @(posedge clock); while (!req_if.ready);
   endtask

   // Hold off the sender until every predicted event has arrived
   task automatic wait_drained();
      req_if.valid <= 1'b0;
      do @(posedge clock); while (sb.pending.size() > 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input reg_index_type idx, input logic [31:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      sb.set_register(idx, value);
   endtask

   task automatic load_config(input logic [31:0] pulse, input logic [31:0] byte_wait,
                              input logic [31:0] clear_wait);
      csr_write(REG_PULSE, pulse);
      csr_write(REG_BYTE_WAIT, byte_wait);
      csr_write(REG_CLEAR_WAIT, clear_wait);
      psel    <= 1'b0;
      penable <= 1'b0;
      settings_used++;
   endtask

   // Mostly writes and cursor moves, with init, clear, home and a few unknown codes
   function automatic lcd_request_type random_request();
      lcd_request_type r;
      int              pick;
      r.byte_value      = 8'($urandom);
      r.register_select = 1'($urandom);
      r.row             = 2'($urandom);
      r.column          = ($urandom_range(0, 9) == 0) ? 6'($urandom_range(40, 63))
                                                      : 6'($urandom_range(0, 39));
      pick = $urandom_range(0, 99);
      if (pick < 45)      r.func = FUNC_WRITE;
      else if (pick < 65) r.func = FUNC_CURSOR;
      else if (pick < 75) r.func = FUNC_CLEAR;
      else if (pick < 83) r.func = FUNC_HOME;
      else if (pick < 93) r.func = FUNC_INIT;
      else                r.func = 3'($urandom_range(5, 7));
      return r;
   endfunction

   task automatic run_random(input int count);
      int              counted;
      lcd_request_type r;
      counted = 0;
      while (counted < count) begin
         r = random_request();
         send_request(r);
         if (r.func <= FUNC_INIT)
            counted++;
         if ($urandom_range(0, 29) == 0)
            wait_drained();
      end
   endtask

   initial begin
      sb            = new();
      steady        = 1'b0;
      settings_used = 1;
      reset         <= 1'b1;
      psel          <= 1'b0;
      penable       <= 1'b0;
      pwrite        <= 1'b0;
      paddr         <= '0;
      pwdata        <= '0;
      req_if.valid           <= 1'b0;
      req_if.func            <= FUNC_WRITE;
      req_if.byte_value      <= 8'h00;
      req_if.register_select <= 1'b0;
      req_if.row             <= 2'd0;
      req_if.column          <= 6'd0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // directed: byte extremes, every row, column wrap, each command, unknown codes
      send_request({FUNC_WRITE,  8'h00, 1'b0, 2'd0, 6'd0});
      send_request({FUNC_WRITE,  8'hFF, 1'b1, 2'd3, 6'd63});
      send_request({FUNC_WRITE,  8'hA5, 1'b1, 2'd0, 6'd0});
      send_request({FUNC_WRITE,  8'h5A, 1'b0, 2'd0, 6'd0});
      send_request({FUNC_CURSOR, 8'h00, 1'b0, 2'd0, 6'd0});
      send_request({FUNC_CURSOR, 8'hFF, 1'b1, 2'd1, 6'd39});
      send_request({FUNC_CURSOR, 8'h00, 1'b0, 2'd2, 6'd17});
      send_request({FUNC_CURSOR, 8'h00, 1'b0, 2'd3, 6'd39});
      send_request({FUNC_CURSOR, 8'h00, 1'b0, 2'd3, 6'd63});
      send_request({FUNC_CURSOR, 8'h00, 1'b0, 2'd1, 6'd63});
      send_request({FUNC_CLEAR,  8'h00, 1'b0, 2'd0, 6'd0});
      send_request({FUNC_HOME,   8'hFF, 1'b1, 2'd3, 6'd63});
      send_request({FUNC_INIT,   8'h00, 1'b0, 2'd0, 6'd0});
      send_request({3'd5,        8'hFF, 1'b1, 2'd3, 6'd63});
      send_request({3'd6,        8'h12, 1'b0, 2'd1, 6'd5});
      send_request({3'd7,        8'h34, 1'b1, 2'd2, 6'd9});
      send_request({FUNC_WRITE,  8'h41, 1'b1, 2'd0, 6'd0});
      send_request({FUNC_INIT,   8'hFF, 1'b1, 2'd3, 6'd63});
      wait_drained();

      // shortest holds, first half without any idling
      load_config(32'd1, 32'd0, 32'd0);
      steady = 1'b1;
      run_random(30);
      steady = 1'b0;
      run_random(30);
      wait_drained();

      // longest holds, every byte-end hold saturates
      load_config(32'd255, 32'd65535, 32'd65535);
      run_random(50);
      wait_drained();

      // zero pulse is out of range but still used
      load_config(32'd0, 32'd65535, 32'd0);
      run_random(50);
      wait_drained();

      // saturate only where the clear wait is added
      load_config(32'd200, 32'd65000, 32'd400);
      run_random(50);
      wait_drained();

      // random settings, upper data bits toggling too
      load_config($urandom, $urandom, $urandom);
      run_random(60);
      wait_drained();

      $display("Checked %0d requests expanding to %0d pin events under %0d register settings",
               sb.requests, sb.events_seen, settings_used);
      $display("%0d mismatches, %0d events still outstanding",
               sb.mismatches, sb.pending.size());
      if (sb.mismatches == 0 && sb.pending.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
